// ===== hdl/hpe_pkg.sv =====
// Shared widths, codes and types for the histogram percentile extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package hpe_pkg;

  localparam int unsigned SUM_W   = 48;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RANK_W  = 10;
  localparam int unsigned NRANK_W = RANK_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RANK_W;

  // Highest usable rank count, and the value of quantile_steps after reset.
  localparam logic [RANK_W-1:0] RANK_LIMIT  = 10'd1000;
  localparam logic [RANK_W-1:0] STEPS_RESET = 10'd100;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTILE_STEPS = 2'd1;

  // Bin queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  // One classified bin: running sum already folded in.
  typedef struct packed {
    logic              first;
    logic [TIME_W-1:0] bin_time;
    logic [SUM_W-1:0]  sum;
  } item_t;

  // Live configuration seen by the rank engine.
  typedef struct packed {
    logic [SUM_W-1:0]  total;
    logic [RANK_W-1:0] steps;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== hdl/histogram_percentile_extractor_core.sv =====
// Path: bin beat, queue, back-end idle state, then result register when the sum has reached
//   the total; a divide adds the product, 10 restoring steps and the result load between.
// Throughput: one bin a cycle into a 4-deep queue while it is not full; the back end takes
//   one bin at a time, one quotient bit a cycle; bins past the last rank emit nothing.
// Reset (rst_ni, async low): running sum 0, next rank 1, total 0, steps 100, queue empty.
`default_nettype none

module histogram_percentile_extractor_core
  import hpe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SUM_W-1:0]     cfg_data_i,
  // bin channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 first_bin_i,
  input  wire logic [TIME_W-1:0]    bin_time_i,
  input  wire logic [SUM_W-1:0]     bin_count_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [TIME_W-1:0]         label_time_o,
  output logic [RANK_W-1:0]         first_rank_o,
  output logic [RANK_W-1:0]         last_rank_o
);

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  logic [SUM_W-1:0]  total_q;
  logic [RANK_W-1:0] steps_q;
  cfg_t              cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      steps_q <= STEPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TOTAL_COUNT:    total_q <= cfg_data_i;
        CFG_QUANTILE_STEPS: steps_q <= cfg_data_i[RANK_W-1:0];
        default:            ;
      endcase
    end
  end

  // Steps of zero behave as one; anything beyond the limit clips to it.
  always_comb begin
    cfg.total = total_q;
    if (steps_q == '0) begin
      cfg.steps = RANK_W'(1);
    end else if (steps_q > RANK_LIMIT) begin
      cfg.steps = RANK_LIMIT;
    end else begin
      cfg.steps = steps_q;
    end
  end

  // Front: running sum, one bin beat a cycle into the queue while it is not full.
  item_t      front_item, back_item;
  logic       push, pop;
  fifo_stat_t fifo_stat;

  hpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_bin_i (first_bin_i),
    .bin_time_i  (bin_time_i),
    .bin_count_i (bin_count_i),
    .full_i      (fifo_stat.full),
    .push_o      (push),
    .item_o      (front_item)
  );

  hpe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .stat_o (fifo_stat)
  );

  // Back: ranks reached, divide, result register (decouples from out_stall_i).
  hpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .avail_i      (!fifo_stat.empty),
    .item_i       (back_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .label_time_o (label_time_o),
    .first_rank_o (first_rank_o),
    .last_rank_o  (last_rank_o)
  );

  // Checks
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_rank_o <= last_rank_o && first_rank_o != '0))
    else $error("result ranks out of order");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_rank_o <= cfg.steps))
    else $error("result rank beyond steps");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("bin queue both full and empty");

  a_pop_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire

// ===== hdl/hpe_front.sv =====
// Front end: accepts bins and keeps the saturating running sum.
// Depends on hpe_pkg; feeds hpe_fifo.
`default_nettype none

module hpe_front
  import hpe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              first_bin_i,
  input  wire logic [TIME_W-1:0] bin_time_i,
  input  wire logic [SUM_W-1:0]  bin_count_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output item_t                  item_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W:0]   sum_wide;

  always_comb begin
    sum_wide = first_bin_i ? {1'b0, bin_count_i}
                           : {1'b0, sum_q} + {1'b0, bin_count_i};
    // saturate at all ones
    sum_d = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  assign in_stall_o      = full_i;
  assign push_o          = in_valid_i && !full_i;
  assign item_o.first    = first_bin_i;
  assign item_o.bin_time = bin_time_i;
  assign item_o.sum      = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (push_o) begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hpe_fifo.sv =====
// Short queue of classified bins between front and back.
// Depends on hpe_pkg.
`default_nettype none

module hpe_fifo
  import hpe_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output fifo_stat_t stat_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hpe_back.sv =====
// Back end: rank tracking, sum*steps product and bit-serial divide by total.
// Depends on hpe_pkg; drains hpe_fifo and owns the result register.
`default_nettype none

module hpe_back
  import hpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               avail_i,
  input  wire item_t              item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [TIME_W-1:0]       label_time_o,
  output logic [RANK_W-1:0]       first_rank_o,
  output logic [RANK_W-1:0]       last_rank_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_e;

  localparam int unsigned      CNT_W    = $clog2(RANK_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RANK_W - 1);

  state_e             state_q;
  logic [NRANK_W-1:0] next_rank_q;
  logic [SUM_W-1:0]   sum_q;
  logic [TIME_W-1:0]  time_q;
  logic [SUM_W-1:0]   rem_q;
  logic [RANK_W-1:0]  quot_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [TIME_W-1:0]  label_time_q;
  logic [RANK_W-1:0]  first_rank_q, last_rank_q;

  logic [NRANK_W-1:0] rank_start;
  logic [PROD_W-1:0]  product;
  logic [SUM_W:0]     shifted, diff;
  logic               ge, out_free, hit, emit;

  always_comb begin
    rank_start = item_i.first ? NRANK_W'(1) : next_rank_q;
    product    = PROD_W'(sum_q) * PROD_W'(cfg_i.steps);
    // restoring step: remainder stays below total, so the borrow alone decides
    shifted    = {rem_q, quot_q[RANK_W-1]};
    diff       = shifted - {1'b0, cfg_i.total};
    ge         = !diff[SUM_W];
    out_free   = !out_valid_q || !out_stall_i;
    hit        = ({1'b0, quot_q} >= next_rank_q);
    emit       = (state_q == S_EMIT) && hit && out_free;
  end

  assign pop_o        = (state_q == S_IDLE) && avail_i;
  assign out_valid_o  = out_valid_q;
  assign label_time_o = label_time_q;
  assign first_rank_o = first_rank_q;
  assign last_rank_o  = last_rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_rank_q  <= NRANK_W'(1);
      sum_q        <= '0;
      time_q       <= '0;
      rem_q        <= '0;
      quot_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      label_time_q <= '0;
      first_rank_q <= '0;
      last_rank_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            sum_q       <= item_i.sum;
            time_q      <= item_i.bin_time;
            next_rank_q <= rank_start;
            if (rank_start > {1'b0, cfg_i.steps}) begin
              state_q <= S_IDLE;      // every rank already reached
            end else if (item_i.sum >= cfg_i.total) begin
              quot_q  <= cfg_i.steps; // quotient clips at steps, zero total too
              state_q <= S_EMIT;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // quotient known to fit RANK_W bits, so the top bits start as remainder
          {rem_q, quot_q} <= product;
          cnt_q           <= '0;
          state_q         <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
          quot_q <= {quot_q[RANK_W-2:0], ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!hit) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            label_time_q <= time_q;
            first_rank_q <= next_rank_q[RANK_W-1:0];
            last_rank_q  <= quot_q;
            next_rank_q  <= {1'b0, quot_q} + NRANK_W'(1);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
